/* rtl/tcc_pkg.sv */
// Shared widths, status codes and the divider stage record for the circumcircle core.
package tcc_pkg;

    // Coordinate width read from each 16-bit input field.
    localparam int CW    = 16;
    localparam int IN_W  = 16;
    localparam int OUT_W = 32;
    // Vertex differences, squared lengths, |D| magnitude and centre products.
    localparam int DW    = CW + 1;
    localparam int SW    = 2 * CW + 1;
    localparam int DMW   = 2 * CW + 2;
    localparam int MW    = DW + SW + 1;
    localparam int NMW   = 3 * CW + 2;
    // Radius numerator and denominator (D squared).
    localparam int RNW   = 3 * SW;
    localparam int RDW   = 2 * DMW;
    // Quotient bits: any centre quotient of 2^QC or more is out of range anyway.
    localparam int QC    = 33;
    localparam int QR    = 48;
    localparam int ND    = QR;
    localparam int VW    = QC + 2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COLIN = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Everything one item carries through the divider stages.
    typedef struct packed {
        logic [CW-1:0]  p1x;
        logic [CW-1:0]  p1y;
        logic           colin;
        logic           xneg;
        logic           yneg;
        logic           xsat;
        logic           ysat;
        logic           rsat;
        logic [DMW-1:0] cden;
        logic [RDW-1:0] rden;
        logic [DMW-1:0] xrem;
        logic [DMW-1:0] yrem;
        logic [QC-1:0]  xlow;
        logic [QC-1:0]  ylow;
        logic [RDW-1:0] rrem;
        logic [QR-1:0]  rlow;
    } t_div;

endpackage

/* rtl/triangle_circumcircle_core.sv */
// Circumscribed circle of a triangle: centre and squared radius, fully pipelined.
//
// Input channel (i_s_*): one item holds the three vertices, signed Q8.8.
// Output channel (o_m_*): one result item per input item, in order: centre x
// and y (signed Q24.8) and squared radius (unsigned Q32.16) in tdata, the
// status code in tuser (ok, collinear points, or saturated result).
// Each item passes from acceptance to the result on o_m_tvalid through
// six arithmetic stages, a set-up stage, one stage per quotient bit of the
// 48-bit radius divider (the 33-bit centre dividers run beside it in its
// first stages) and the output register.
// Unless the output stalls, throughput is one item per cycle; the restoring
// dividers are unrolled into stages of one compare and subtract each, so a new
// item enters every cycle. Collinear points give zero fields and status 1. An
// out-of-range centre or radius is clamped and gives status 2.
// When the receiver stalls a finished result, the whole pipeline holds and
// o_s_tready drops; nothing is lost or repeated. Reset clears every valid bit.
module triangle_circumcircle_core
    import tcc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // first_x, first_y, second_x, second_y, third_x, third_y (16 bits each)
    input  logic [95:0]  i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // center_x (32), center_y (32), radius_sq (48)
    output logic [111:0] o_m_tdata,
    // status (2)
    output logic [1:0]   o_m_tuser
);

    logic w_adv;
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // Stage 1: vertex differences.
    logic                 r_v1;
    logic signed [CW-1:0] r1_p1x, r1_p1y;
    logic signed [DW-1:0] r1_bx, r1_by, r1_cx, r1_cy, r1_ax, r1_ay;
    logic signed [CW-1:0] w_p [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_p[i] = $signed(i_s_tdata[i*IN_W +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p1x <= w_p[0];
            r1_p1y <= w_p[1];
            r1_bx  <= DW'(w_p[2]) - DW'(w_p[0]);
            r1_by  <= DW'(w_p[3]) - DW'(w_p[1]);
            r1_cx  <= DW'(w_p[4]) - DW'(w_p[0]);
            r1_cy  <= DW'(w_p[5]) - DW'(w_p[1]);
            r1_ax  <= DW'(w_p[4]) - DW'(w_p[2]);
            r1_ay  <= DW'(w_p[5]) - DW'(w_p[3]);
        end
    end

    // Stage 2: cross terms and squares.
    logic                   r_v2;
    logic signed [CW-1:0]   r2_p1x, r2_p1y;
    logic signed [DW-1:0]   r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [2*DW-1:0] r2_bxcy, r2_bycx, r2_bxx, r2_byy, r2_cxx, r2_cyy, r2_axx, r2_ayy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_p1x  <= r1_p1x;
            r2_p1y  <= r1_p1y;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_bxcy <= r1_bx * r1_cy;
            r2_bycx <= r1_by * r1_cx;
            r2_bxx  <= r1_bx * r1_bx;
            r2_byy  <= r1_by * r1_by;
            r2_cxx  <= r1_cx * r1_cx;
            r2_cyy  <= r1_cy * r1_cy;
            r2_axx  <= r1_ax * r1_ax;
            r2_ayy  <= r1_ay * r1_ay;
        end
    end

    // Stage 3: the determinant D and the squared side lengths.
    logic                     r_v3;
    logic signed [CW-1:0]     r3_p1x, r3_p1y;
    logic signed [DW-1:0]     r3_bx, r3_by, r3_cx, r3_cy;
    logic        [SW-1:0]     r3_a2, r3_b2, r3_c2;
    logic        [DMW-1:0]    r3_dmag;
    logic                     r3_dneg, r3_dzero;
    logic signed [2*DW:0]     w_cross;
    logic        [2*DW:0]     w_cabs;

    always_comb begin
        w_cross = (2*DW+1)'(r2_bxcy) - (2*DW+1)'(r2_bycx);
        w_cabs  = w_cross[2*DW] ? (2*DW+1)'(-w_cross) : w_cross;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_p1x   <= r2_p1x;
            r3_p1y   <= r2_p1y;
            r3_bx    <= r2_bx;
            r3_by    <= r2_by;
            r3_cx    <= r2_cx;
            r3_cy    <= r2_cy;
            r3_b2    <= {1'b0, r2_bxx[2*CW-1:0]} + {1'b0, r2_byy[2*CW-1:0]};
            r3_c2    <= {1'b0, r2_cxx[2*CW-1:0]} + {1'b0, r2_cyy[2*CW-1:0]};
            r3_a2    <= {1'b0, r2_axx[2*CW-1:0]} + {1'b0, r2_ayy[2*CW-1:0]};
            r3_dmag  <= {w_cabs[DMW-2:0], 1'b0};
            r3_dneg  <= w_cross[2*DW];
            r3_dzero <= (w_cross == '0);
        end
    end

    // Stage 4: centre numerator products, a2*b2 and D squared.
    logic                   r_v4;
    logic signed [CW-1:0]   r4_p1x, r4_p1y;
    logic signed [MW-1:0]   r4_m1, r4_m2, r4_m3, r4_m4;
    logic        [2*SW-1:0] r4_ab;
    logic        [SW-1:0]   r4_c2;
    logic        [RDW-1:0]  r4_dd;
    logic        [DMW-1:0]  r4_dmag;
    logic                   r4_dneg, r4_dzero;
    logic signed [SW:0]     w_b2s, w_c2s;

    assign w_b2s = $signed({1'b0, r3_b2});
    assign w_c2s = $signed({1'b0, r3_c2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_p1x   <= r3_p1x;
            r4_p1y   <= r3_p1y;
            r4_m1    <= r3_cy * w_b2s;
            r4_m2    <= r3_by * w_c2s;
            r4_m3    <= r3_bx * w_c2s;
            r4_m4    <= r3_cx * w_b2s;
            r4_ab    <= r3_a2 * r3_b2;
            r4_c2    <= r3_c2;
            r4_dd    <= r3_dmag * r3_dmag;
            r4_dmag  <= r3_dmag;
            r4_dneg  <= r3_dneg;
            r4_dzero <= r3_dzero;
        end
    end

    // Stage 5: centre numerators as sign and magnitude; radius partial products.
    logic                   r_v5;
    logic signed [CW-1:0]   r5_p1x, r5_p1y;
    logic        [NMW-1:0]  r5_nxm, r5_nym;
    logic                   r5_nxneg, r5_nyneg;
    logic        [2*SW-1:0] r5_rlo, r5_rhi;
    logic        [RDW-1:0]  r5_dd;
    logic        [DMW-1:0]  r5_dmag;
    logic                   r5_dneg, r5_dzero;
    logic signed [MW:0]     w_nx, w_ny;
    logic        [MW:0]     w_nxa, w_nya;

    always_comb begin
        w_nx  = (MW+1)'(r4_m1) - (MW+1)'(r4_m2);
        w_ny  = (MW+1)'(r4_m3) - (MW+1)'(r4_m4);
        w_nxa = w_nx[MW] ? (MW+1)'(-w_nx) : w_nx;
        w_nya = w_ny[MW] ? (MW+1)'(-w_ny) : w_ny;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_adv) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_p1x   <= r4_p1x;
            r5_p1y   <= r4_p1y;
            r5_nxm   <= w_nxa[NMW-1:0];
            r5_nym   <= w_nya[NMW-1:0];
            r5_nxneg <= w_nx[MW];
            r5_nyneg <= w_ny[MW];
            r5_rlo   <= r4_ab[SW-1:0] * r4_c2;
            r5_rhi   <= r4_ab[2*SW-1:SW] * r4_c2;
            r5_dd    <= r4_dd;
            r5_dmag  <= r4_dmag;
            r5_dneg  <= r4_dneg;
            r5_dzero <= r4_dzero;
        end
    end

    // Stage 6: full radius numerator a2*b2*c2.
    logic                 r_v6;
    logic signed [CW-1:0] r6_p1x, r6_p1y;
    logic        [NMW-1:0] r6_nxm, r6_nym;
    logic                 r6_xneg, r6_yneg;
    logic        [RNW-1:0] r6_rnum;
    logic        [RDW-1:0] r6_dd;
    logic        [DMW-1:0] r6_dmag;
    logic                 r6_dzero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_adv) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r6_p1x   <= r5_p1x;
            r6_p1y   <= r5_p1y;
            r6_nxm   <= r5_nxm;
            r6_nym   <= r5_nym;
            r6_xneg  <= r5_nxneg ^ r5_dneg;
            r6_yneg  <= r5_nyneg ^ r5_dneg;
            r6_rnum  <= (RNW'(r5_rhi) << SW) + RNW'(r5_rlo);
            r6_dd    <= r5_dd;
            r6_dmag  <= r5_dmag;
            r6_dzero <= r5_dzero;
        end
    end

    // Divider set-up: range checks and the first partial remainders.
    t_div w_init;

    always_comb begin
        w_init       = '0;
        w_init.p1x   = r6_p1x;
        w_init.p1y   = r6_p1y;
        w_init.colin = r6_dzero;
        w_init.xneg  = r6_xneg;
        w_init.yneg  = r6_yneg;
        w_init.cden  = r6_dmag;
        w_init.rden  = r6_dd;
        w_init.xsat  = DMW'(r6_nxm[NMW-1:QC]) >= r6_dmag;
        w_init.ysat  = DMW'(r6_nym[NMW-1:QC]) >= r6_dmag;
        w_init.rsat  = RDW'(r6_rnum[RNW-1:QR]) >= r6_dd;
        w_init.xrem  = DMW'(r6_nxm[NMW-1:QC]);
        w_init.yrem  = DMW'(r6_nym[NMW-1:QC]);
        w_init.xlow  = r6_nxm[QC-1:0];
        w_init.ylow  = r6_nym[QC-1:0];
        w_init.rrem  = RDW'(r6_rnum[RNW-1:QR]);
        w_init.rlow  = r6_rnum[QR-1:0];
    end

    // One restoring step per stage; quotient bits shift in behind the numerator bits.
    function automatic t_div div_step(input t_div s, input logic en_c);
        t_div           o;
        logic [DMW:0]   tx;
        logic [DMW:0]   ty;
        logic [RDW:0]   tr;
        logic           qx;
        logic           qy;
        logic           qr;
        o  = s;
        tr = {s.rrem, s.rlow[QR-1]};
        qr = tr >= {1'b0, s.rden};
        o.rrem = qr ? RDW'(tr - {1'b0, s.rden}) : tr[RDW-1:0];
        o.rlow = {s.rlow[QR-2:0], qr};
        tx = {s.xrem, s.xlow[QC-1]};
        ty = {s.yrem, s.ylow[QC-1]};
        qx = tx >= {1'b0, s.cden};
        qy = ty >= {1'b0, s.cden};
        if (en_c) begin
            o.xrem = qx ? DMW'(tx - {1'b0, s.cden}) : tx[DMW-1:0];
            o.xlow = {s.xlow[QC-2:0], qx};
            o.yrem = qy ? DMW'(ty - {1'b0, s.cden}) : ty[DMW-1:0];
            o.ylow = {s.ylow[QC-2:0], qy};
        end
        return o;
    endfunction

    t_div r_dv  [0:ND];
    logic r_dvv [0:ND];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (w_adv) begin
            r_dvv[0] <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0] <= w_init;
        end
    end

    for (genvar k = 0; k < ND; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dvv[k+1] <= r_dvv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k+1] <= div_step(r_dv[k], (k < QC) ? 1'b1 : 1'b0);
            end
        end
    end

    // Final stage: apply the quotient signs, clamp and pick the status.
    t_div                  w_f;
    logic signed [VW-1:0]  w_vx, w_vy;
    logic                  w_xok, w_yok, w_xneg, w_yneg, w_sat;
    logic [OUT_W-1:0]      w_cx, w_cy;
    logic [QR-1:0]         w_r;
    logic [111:0]          n_tdata;
    logic [1:0]            n_tuser;
    logic [111:0]          r_tdata;
    logic [1:0]            r_tuser;
    logic                  r_ovalid;

    localparam logic [OUT_W-1:0] C_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] C_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    always_comb begin
        w_f  = r_dv[ND];
        w_vx = w_f.xneg ? VW'($signed(w_f.p1x)) - $signed({2'b00, w_f.xlow})
                        : VW'($signed(w_f.p1x)) + $signed({2'b00, w_f.xlow});
        w_vy = w_f.yneg ? VW'($signed(w_f.p1y)) - $signed({2'b00, w_f.ylow})
                        : VW'($signed(w_f.p1y)) + $signed({2'b00, w_f.ylow});
        w_xok  = !w_f.xsat && ((w_vx[VW-1:OUT_W-1] == '0) || (w_vx[VW-1:OUT_W-1] == '1));
        w_yok  = !w_f.ysat && ((w_vy[VW-1:OUT_W-1] == '0) || (w_vy[VW-1:OUT_W-1] == '1));
        w_xneg = w_f.xsat ? w_f.xneg : w_vx[VW-1];
        w_yneg = w_f.ysat ? w_f.yneg : w_vy[VW-1];
        w_cx   = w_xok ? w_vx[OUT_W-1:0] : (w_xneg ? C_MIN : C_MAX);
        w_cy   = w_yok ? w_vy[OUT_W-1:0] : (w_yneg ? C_MIN : C_MAX);
        w_r    = w_f.rsat ? {QR{1'b1}} : w_f.rlow;
        w_sat  = !w_xok || !w_yok || w_f.rsat;
        if (w_f.colin) begin
            n_tdata = '0;
            n_tuser = ST_COLIN;
        end else begin
            n_tdata = {w_r, w_cy, w_cx};
            n_tuser = w_sat ? ST_SAT : ST_OK;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= r_dvv[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

endmodule

/* rtl/tcc_checker.sv */
// Port-level checks on the circumcircle core, bound to the top level.
module tcc_checker
    import tcc_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [95:0]  i_s_tdata,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [111:0] o_m_tdata,
    input logic [1:0]   o_m_tuser
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // The input side is held exactly while a result is stalled.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == !(o_m_tvalid && !i_m_tready))
        else $error("input ready does not follow output stall");

    // Collinear points give all-zero fields.
    a_colin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_COLIN) |-> (o_m_tdata == '0))
        else $error("collinear result with nonzero fields");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind triangle_circumcircle_core tcc_checker u_tcc_checker (.*);
